>>> rtl/string_literal_scanner_assert.svh
// Assertion macros for the string literal scanner.
// Used by the top level; depends on no other file.
`ifndef STRING_LITERAL_SCANNER_ASSERT_SVH
`define STRING_LITERAL_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SLS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sls_pkg.sv
// Shared types and constants for the string literal scanner.
// No dependencies; used by the lane, merge and top-level modules.
package sls_pkg;

    localparam int CNT_W     = 4;
    localparam int COUNT_W   = 32;

    localparam logic [7:0]         BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0]         BYTE_ESCAPE  = 8'h5C;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic is_quote;
        logic is_escape;
        logic is_newline;
    } lane_class_t;

    typedef struct packed {
        logic             closed;
        logic             esc_out;
        logic             nl_any;
        logic [CNT_W-1:0] consumed;
        logic [CNT_W-1:0] nl_count;
        logic [CNT_W-1:0] tail_len;
    } merge_t;

endpackage

>>> rtl/sls_lane.sv
// One byte lane of the string literal scanner: classifies a source byte.
// Depends on sls_pkg.
module sls_lane (
    input  logic [7:0]          lane_byte,
    input  logic [7:0]          quote_char,
    output sls_pkg::lane_class_t lane_class
);

    always_comb begin
        lane_class.is_quote   = (lane_byte == quote_char);
        lane_class.is_escape  = (lane_byte == sls_pkg::BYTE_ESCAPE);
        lane_class.is_newline = (lane_byte == sls_pkg::BYTE_NEWLINE);
    end

endmodule

>>> rtl/sls_merge.sv
// Merging stage: resolves escapes across lanes, finds the closing quote and
// counts consumed bytes and newlines. Depends on sls_pkg.
module sls_merge #(
    parameter int LANES = 8
) (
    input  sls_pkg::lane_class_t             lane_class [LANES],
    input  logic [sls_pkg::CNT_W-1:0]        count,
    input  logic                             esc_in,
    output sls_pkg::merge_t                  result
);

    always_comb begin
        logic                      esc;
        logic                      closed;
        logic                      nl_any;
        logic [sls_pkg::CNT_W-1:0] consumed;
        logic [sls_pkg::CNT_W-1:0] nl_count;
        logic [sls_pkg::CNT_W-1:0] nl_last;
        esc      = esc_in;
        closed   = 1'b0;
        nl_any   = 1'b0;
        consumed = count;
        nl_count = '0;
        nl_last  = '0;
        for (int i = 0; i < LANES; i++) begin
            if ((sls_pkg::CNT_W'(i) < count) && !closed) begin
                if (esc) begin
                    esc = 1'b0;
                end else if (lane_class[i].is_quote) begin
                    closed   = 1'b1;
                    consumed = sls_pkg::CNT_W'(i + 1);
                end else if (lane_class[i].is_escape) begin
                    esc = 1'b1;
                end else if (lane_class[i].is_newline) begin
                    nl_any   = 1'b1;
                    nl_count = nl_count + sls_pkg::CNT_W'(1);
                    nl_last  = sls_pkg::CNT_W'(i);
                end
            end
        end
        result.closed   = closed;
        result.esc_out  = esc;
        result.nl_any   = nl_any;
        result.consumed = consumed;
        result.nl_count = nl_count;
        result.tail_len = consumed - nl_last;
    end

endmodule

>>> rtl/string_literal_scanner.sv
// String literal scanner. One chunk of up to LANES source bytes is taken per
// request on the s_ channel (valid/ready) and classified by LANES byte lanes
// side by side; a merging stage resolves escapes, finds the closing quote and
// counts bytes and newlines, and the running counters update in the same cycle.
//
// Usage: send a chunk with s_begin_req high right after the opening quote,
// then further chunks. A result appears on the m_ channel when the configured
// quote byte closes the literal, or on a chunk with s_last high if it does
// not. Bytes after the quote in the same chunk are dropped.
// The result is registered and valid in the cycle after the request that caused it.
// Throughput: one chunk per cycle while the receiver keeps up; the loop through the
// lanes, the escape chain and the 32-bit saturating counter adds sets this figure.
// A request is taken whenever the output register is empty or being read.
// If the receiver stalls, the result holds in the output register and the
// input stops until that result is read.
// Reset (aresetn low, synchronous) closes any open scan, clears the counters,
// empties the output register and sets the quote byte to 34.
// Depends on sls_pkg, sls_lane, sls_merge and string_literal_scanner_assert.svh.
`include "string_literal_scanner_assert.svh"

module string_literal_scanner #(
    parameter int LANES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_begin_req,
    input  logic [63:0] s_chunk_bytes,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_advance,
    output logic [31:0] m_newline_count,
    output logic [31:0] m_tail_column,
    output logic        m_closed
);

    localparam logic [sls_pkg::CNT_W-1:0] LANES_CNT = sls_pkg::CNT_W'(LANES);

    logic [7:0]                  quote_reg;
    logic                        scanning_reg, scanning_next;
    logic                        esc_reg, esc_next;
    logic [31:0]                 total_reg, total_next;
    logic [31:0]                 lines_reg, lines_next;
    logic [31:0]                 column_reg, column_next;
    logic                        m_valid_reg, m_valid_next;
    logic [31:0]                 adv_reg, lines_out_reg, col_out_reg;
    logic                        closed_reg;

    logic                        accept;
    logic                        scan_eff;
    logic                        esc_eff;
    logic [31:0]                 total_eff, lines_eff, column_eff;
    logic [31:0]                 total_sum, lines_sum, column_sum;
    logic [sls_pkg::CNT_W-1:0]   count_eff;
    logic                        produce;
    sls_pkg::lane_class_t        lane_class [LANES];
    sls_pkg::merge_t             merged;

    function automatic logic [31:0] sat_add(input logic [31:0] a,
                                            input logic [sls_pkg::CNT_W-1:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + 33'(b);
        return sum[32] ? sls_pkg::COUNT_MAX : sum[31:0];
    endfunction

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign count_eff = (s_byte_count > LANES_CNT) ? LANES_CNT : s_byte_count;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        sls_lane u_lane (
            .lane_byte  (s_chunk_bytes[8*i +: 8]),
            .quote_char (quote_reg),
            .lane_class (lane_class[i])
        );
    end

    sls_merge #(.LANES(LANES)) u_merge (
        .lane_class (lane_class),
        .count      (count_eff),
        .esc_in     (esc_eff),
        .result     (merged)
    );

    always_comb begin
        scan_eff   = s_begin_req || scanning_reg;
        esc_eff    = s_begin_req ? 1'b0  : esc_reg;
        total_eff  = s_begin_req ? 32'd0 : total_reg;
        lines_eff  = s_begin_req ? 32'd0 : lines_reg;
        column_eff = s_begin_req ? 32'd0 : column_reg;

        total_sum  = sat_add(total_eff, merged.consumed);
        lines_sum  = sat_add(lines_eff, merged.nl_count);
        column_sum = merged.nl_any ? 32'(merged.tail_len)
                                   : sat_add(column_eff, merged.consumed);
        produce    = scan_eff && (merged.closed || s_last);

        scanning_next = scanning_reg;
        esc_next      = esc_reg;
        total_next    = total_reg;
        lines_next    = lines_reg;
        column_next   = column_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (accept && scan_eff) begin
            total_next  = total_sum;
            lines_next  = lines_sum;
            column_next = column_sum;
            if (produce) begin
                scanning_next = 1'b0;
                esc_next      = 1'b0;
                m_valid_next  = 1'b1;
            end else begin
                scanning_next = 1'b1;
                esc_next      = merged.esc_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_reg    <= 8'd34;
            scanning_reg <= 1'b0;
            esc_reg      <= 1'b0;
            total_reg    <= '0;
            lines_reg    <= '0;
            column_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                quote_reg <= cfg_wdata;
            end
            scanning_reg <= scanning_next;
            esc_reg      <= esc_next;
            total_reg    <= total_next;
            lines_reg    <= lines_next;
            column_reg   <= column_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && produce) begin
            adv_reg       <= total_sum;
            lines_out_reg <= lines_sum;
            col_out_reg   <= column_sum;
            closed_reg    <= merged.closed;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_advance       = adv_reg;
    assign m_newline_count = lines_out_reg;
    assign m_tail_column   = col_out_reg;
    assign m_closed        = closed_reg;

    `SLS_ASSERT_NOW(a_closed_nonzero, aclk, aresetn, m_valid_reg && closed_reg,
        adv_reg != 32'd0, "closed result with zero advance")
    `SLS_ASSERT_NOW(a_col_le_adv, aclk, aresetn, m_valid_reg,
        col_out_reg <= adv_reg, "tail column exceeds advance")
    `SLS_ASSERT_NOW(a_nl_le_adv, aclk, aresetn, m_valid_reg,
        lines_out_reg <= adv_reg, "newline count exceeds advance")
    `SLS_ASSERT_NEXT(a_result_ends_scan, aclk, aresetn, accept && produce,
        !scanning_reg && m_valid_reg, "scan still open after result")
    `SLS_ASSERT_NOW(a_idle_no_escape, aclk, aresetn, !scanning_reg,
        !esc_reg, "escape pending with no open scan")

endmodule
